[rtl/core/mspc_pkg.sv]
// Package for the median stepped fan pressure controller.
// Sample, speed and error types, register indexes, step table and reset values.
// No dependencies.
package mspc_pkg;

    localparam int DEF_WINDOW_SIZE = 5;

    typedef logic signed [15:0] sample_t;
    typedef logic [15:0]        speed_t;
    typedef logic [7:0]         byte_t;
    typedef logic signed [17:0] err_t;
    typedef logic [3:0]         fail_t;
    typedef logic [1:0]         cfg_index_t;

    localparam cfg_index_t REG_REFERENCE = 2'd0;
    localparam cfg_index_t REG_BAND      = 2'd1;
    localparam cfg_index_t REG_LIMIT     = 2'd2;

    localparam byte_t  RESET_REFERENCE = 8'd22;
    localparam byte_t  RESET_BAND      = 8'd1;
    localparam speed_t RESET_LIMIT     = 16'd20000;

    localparam err_t ERR_40 = 18'sd40;
    localparam err_t ERR_30 = 18'sd30;
    localparam err_t ERR_20 = 18'sd20;
    localparam err_t ERR_10 = 18'sd10;

    localparam speed_t STEP_4000 = 16'd4000;
    localparam speed_t STEP_3000 = 16'd3000;
    localparam speed_t STEP_2000 = 16'd2000;
    localparam speed_t STEP_1000 = 16'd1000;
    localparam speed_t STEP_NONE = 16'd0;
    localparam speed_t STEP_FINE = 16'd100;

    localparam fail_t FAIL_LIMIT = 4'd6;
    localparam fail_t FAIL_MAX   = 4'd15;

    // Coarse step for a positive error magnitude; zero below the smallest band.
    function automatic speed_t coarse_step(input err_t e);
        speed_t st;
        if (e >= ERR_40)
        begin
            st = STEP_4000;
        end
        else if (e >= ERR_30)
        begin
            st = STEP_3000;
        end
        else if (e >= ERR_20)
        begin
            st = STEP_2000;
        end
        else if (e >= ERR_10)
        begin
            st = STEP_1000;
        end
        else
        begin
            st = STEP_NONE;
        end
        return st;
    endfunction

endpackage

[rtl/core/mspc_median.sv]
// Rank-select median of a small window of signed samples.
// Depends on mspc_pkg for the sample type.
module mspc_median
    import mspc_pkg::*;
#(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
)
(
    input  sample_t window [WINDOW_SIZE],
    output sample_t median
);

    localparam int RW  = $clog2(WINDOW_SIZE);
    localparam int MID = WINDOW_SIZE / 2;

    logic [RW-1:0] rank [WINDOW_SIZE];

    // Rank of each entry in sorted order; equal values break ties by position.
    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_rank
        always_comb
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++)
            begin
                if ((window[j] < window[i]) || ((j < i) && (window[j] == window[i])))
                begin
                    rank[i] = rank[i] + RW'(1);
                end
            end
        end
    end

    always_comb
    begin
        median = window[0];
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (rank[i] == RW'(MID))
            begin
                median = window[i];
            end
        end
    end

endmodule

[rtl/core/median_stepped_fan_pressure_control.sv]
// Top level of the median stepped fan pressure controller.
// Depends on mspc_pkg and mspc_median.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  sample   | sample_valid, sample_stall | pressure_sample
//  result   | result_valid, result_stall | speed_command, median_pressure,
//           |                            | speed_changed, target_reached
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One sample is accepted per cycle while sample_stall is low; it waits in the input
// register, and the sample that fills the window yields a result in the output
// register. Reset clears the counters and fan speed and loads the configuration
// defaults; the window holds no reset value. Sample input stalls only while a
// window-completing transaction waits behind a full, stalled output register.
module median_stepped_fan_pressure_control
    import mspc_pkg::*;
#(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       sample_valid,
    output logic       sample_stall,
    input  sample_t    pressure_sample,

    output logic       result_valid,
    input  logic       result_stall,
    output speed_t     speed_command,
    output sample_t    median_pressure,
    output logic       speed_changed,
    output logic       target_reached,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  speed_t     cfg_data
);

    localparam int CW = $clog2(WINDOW_SIZE);

    // configuration
    byte_t   reference_reg;
    byte_t   band_reg;
    speed_t  limit_reg;

    // input stage and window
    logic    in_valid_reg;
    sample_t sample_reg;
    sample_t window_reg [WINDOW_SIZE];
    sample_t window_eff [WINDOW_SIZE];
    logic [CW-1:0] count_reg;

    // control state
    speed_t  speed_reg;
    speed_t  speed_next;
    fail_t   fail_reg;
    fail_t   fail_next;
    logic    changed_next;

    // output stage
    logic    out_valid_reg;
    speed_t  out_speed_reg;
    sample_t out_median_reg;
    logic    out_changed_reg;
    logic    out_reached_reg;

    logic    window_done;
    logic    out_free;
    logic    in_advance;
    logic    result_load;
    logic    sample_take;

    sample_t median;
    err_t    err;
    err_t    acc;
    err_t    neg_acc;
    err_t    headroom;
    speed_t  step_lower;
    speed_t  step_raise;
    logic [16:0] fine_sum;

    assign cfg_ready = 1'b1;

    assign window_done  = (count_reg == CW'(WINDOW_SIZE - 1));
    assign out_free     = !out_valid_reg || !result_stall;
    assign in_advance   = in_valid_reg && (!window_done || out_free);
    assign result_load  = in_advance && window_done;
    assign sample_stall = in_valid_reg && !in_advance;
    assign sample_take  = sample_valid && !sample_stall;

    // Window as it stands once the held sample is written in.
    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_eff
        assign window_eff[i] = (count_reg == CW'(i)) ? sample_reg : window_reg[i];
    end

    mspc_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_median (
        .window (window_eff),
        .median (median)
    );

    assign err        = err_t'(median) - err_t'({10'd0, reference_reg});
    assign acc        = err_t'({10'd0, band_reg});
    assign neg_acc    = -acc;
    assign step_lower = coarse_step(err);
    assign step_raise = coarse_step(-err);
    assign headroom   = err_t'({2'd0, limit_reg}) - err_t'({2'd0, step_raise});
    assign fine_sum   = {1'b0, speed_reg} + {1'b0, STEP_FINE};

    always_comb
    begin
        speed_next   = speed_reg;
        fail_next    = fail_reg;
        changed_next = 1'b0;
        if (err > acc)
        begin
            // pressure too high: lower the fan
            if (speed_reg != '0)
            begin
                changed_next = 1'b1;
                if ((step_lower != STEP_NONE) && (speed_reg >= step_lower))
                begin
                    speed_next = speed_reg - step_lower;
                end
                else
                begin
                    speed_next = (speed_reg >= STEP_FINE) ? speed_reg - STEP_FINE : '0;
                    fail_next  = '0;
                end
            end
        end
        else if (err < neg_acc)
        begin
            // pressure too low: raise the fan, or count a failed raise at the limit
            if (speed_reg < limit_reg)
            begin
                changed_next = 1'b1;
                fail_next    = '0;
                if ((step_raise != STEP_NONE) && (err_t'({2'd0, speed_reg}) < headroom))
                begin
                    speed_next = speed_reg + step_raise;
                end
                else if (fine_sum > {1'b0, limit_reg})
                begin
                    speed_next = limit_reg;
                end
                else
                begin
                    speed_next = fine_sum[15:0];
                end
            end
            else if (fail_reg < FAIL_MAX)
            begin
                fail_next = fail_reg + fail_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_reg <= RESET_REFERENCE;
            band_reg      <= RESET_BAND;
            limit_reg     <= RESET_LIMIT;
            in_valid_reg  <= 1'b0;
            count_reg     <= '0;
            speed_reg     <= '0;
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_REFERENCE: reference_reg <= cfg_data[7:0];
                    REG_BAND:      band_reg      <= cfg_data[7:0];
                    REG_LIMIT:     limit_reg     <= cfg_data;
                    default:       ;
                endcase
            end

            if (sample_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (in_advance)
            begin
                count_reg <= window_done ? '0 : count_reg + CW'(1);
            end

            if (result_load)
            begin
                speed_reg     <= speed_next;
                fail_reg      <= fail_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            sample_reg <= pressure_sample;
        end
        if (in_advance)
        begin
            window_reg[count_reg] <= sample_reg;
        end
        if (result_load)
        begin
            out_speed_reg   <= speed_next;
            out_median_reg  <= median;
            out_changed_reg <= changed_next;
            out_reached_reg <= (fail_next <= FAIL_LIMIT);
        end
    end

    assign result_valid    = out_valid_reg;
    assign speed_command   = out_speed_reg;
    assign median_pressure = out_median_reg;
    assign speed_changed   = out_changed_reg;
    assign target_reached  = out_reached_reg;

endmodule
